// ----- hw/rtl/mvsa_pkg.sv -----
// Shared types and constants for the MIDI voice slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mvsa_pkg;

  localparam int CHANNEL_W  = 4;
  localparam int NOTE_W     = 7;
  localparam int VELOCITY_W = 7;
  localparam int SLOT_OUT_W = 3;
  localparam int STAMP_W    = 32;
  localparam int WORD_W     = NOTE_W + 1 + STAMP_W;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int MASK_W      = 16;
  localparam int VOICES_W    = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOICES_IN_USE  = 1'd1;

  localparam logic [MASK_W-1:0]   MASK_RESET   = 16'd239;
  localparam logic [VOICES_W-1:0] VOICES_RESET = 4'd8;
  localparam logic [STAMP_W-1:0]  STAMP_RESET  = 32'd1;

  localparam logic KIND_NOTE_ON  = 1'b0;
  localparam logic KIND_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic search;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic ignored;
    logic search_done;
    logic emit;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mvsa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the per-slot note, active flag and start stamp.
`default_nettype none

module mvsa_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mvsa_ctrl.sv -----
// Sequencing state machine of the MIDI voice slot allocator.
// Depends on mvsa_pkg for the command and status structs.
`default_nettype none

module mvsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mvsa_pkg::status_t st,
  output mvsa_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (st.ignored) begin
          state_next = S_IDLE;
        end else if (st.search_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!st.emit) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mvsa_datapath.sv -----
// Datapath of the MIDI voice slot allocator: configuration, event and search
// registers, stamp counter, slot RAM and output register. Uses mvsa_pkg, mvsa_ram.
`default_nettype none

module mvsa_datapath #(
  parameter int MAX_VOICES    = 8,
  parameter int MIDI_CHANNELS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mvsa_pkg::cmd_t                       cmd,
  output mvsa_pkg::status_t                    st,
  input  logic                                 cfg_write,
  input  logic [mvsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mvsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 kind,
  input  logic [mvsa_pkg::CHANNEL_W-1:0]       midi_channel,
  input  logic [mvsa_pkg::NOTE_W-1:0]          note_number,
  input  logic [mvsa_pkg::VELOCITY_W-1:0]      note_velocity,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 starts_voice,
  output logic [mvsa_pkg::CHANNEL_W-1:0]       out_channel,
  output logic [mvsa_pkg::SLOT_OUT_W-1:0]      voice_slot,
  output logic [mvsa_pkg::NOTE_W-1:0]          out_note,
  output logic [mvsa_pkg::VELOCITY_W-1:0]      out_velocity
);

  localparam int SLOTS = MAX_VOICES * MIDI_CHANNELS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int VW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW    = $clog2(MAX_VOICES + 1);

  logic [mvsa_pkg::MASK_W-1:0]     enable_mask;
  logic [mvsa_pkg::VOICES_W-1:0]   voices;
  logic [mvsa_pkg::STAMP_W-1:0]    stamp_counter;
  logic [AW-1:0]                   clr_addr;

  logic                            ev_kind;
  logic [mvsa_pkg::CHANNEL_W-1:0]  ev_channel;
  logic [mvsa_pkg::NOTE_W-1:0]     ev_note;
  logic [mvsa_pkg::VELOCITY_W-1:0] ev_velocity;

  logic [CW-1:0]                   issue_idx;
  logic                            chk_valid;
  logic [VW-1:0]                   chk_idx;
  logic                            found;
  logic [VW-1:0]                   pick;
  logic [mvsa_pkg::STAMP_W-1:0]    least;

  logic [CW-1:0]                   search_n;
  logic                            is_on;
  logic                            ch_ok;
  logic                            issuing;
  logic                            checking;
  logic                            hit;
  logic [AW-1:0]                   slot_base;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic [mvsa_pkg::WORD_W-1:0]     ram_wdata;
  logic [mvsa_pkg::WORD_W-1:0]     ram_rdata;

  logic [mvsa_pkg::NOTE_W-1:0]     rd_note;
  logic                            rd_active;
  logic [mvsa_pkg::STAMP_W-1:0]    rd_stamp;

  assign search_n = ({2'b00, voices} > 6'(MAX_VOICES)) ? CW'(MAX_VOICES) : CW'(voices);
  assign is_on    = (ev_kind == mvsa_pkg::KIND_NOTE_ON) && (ev_velocity != '0);
  assign ch_ok    = ({1'b0, ev_channel} < 5'(MIDI_CHANNELS)) && enable_mask[ev_channel];
  assign slot_base = AW'(ev_channel * MAX_VOICES);

  assign rd_note   = ram_rdata[mvsa_pkg::WORD_W-1 -: mvsa_pkg::NOTE_W];
  assign rd_active = ram_rdata[mvsa_pkg::STAMP_W];
  assign rd_stamp  = ram_rdata[mvsa_pkg::STAMP_W-1:0];

  assign issuing  = cmd.search && !found && (issue_idx < search_n);
  assign checking = chk_valid && !found;
  assign hit      = checking && (is_on ? !rd_active : (rd_note == ev_note));

  assign ram_raddr = slot_base + AW'(issue_idx[VW-1:0]);
  assign ram_we    = cmd.clear || cmd.commit;
  assign ram_waddr = cmd.clear ? clr_addr : (slot_base + AW'(pick));
  assign ram_wdata = cmd.clear ? '0 : {ev_note, is_on, (is_on ? stamp_counter : least)};

  assign st.clear_last  = (clr_addr == AW'(SLOTS - 1));
  assign st.ignored     = !ch_ok;
  assign st.search_done = found || ((issue_idx == search_n) && !chk_valid);
  assign st.emit        = is_on || found;
  assign st.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask   <= mvsa_pkg::MASK_RESET;
      voices        <= mvsa_pkg::VOICES_RESET;
      stamp_counter <= mvsa_pkg::STAMP_RESET;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      issue_idx     <= '0;
      chk_valid     <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mvsa_pkg::REG_CHANNEL_ENABLE: enable_mask <= cfg_data[mvsa_pkg::MASK_W-1:0];
          mvsa_pkg::REG_VOICES_IN_USE:  voices <= cfg_data[mvsa_pkg::VOICES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (is_on) begin
          stamp_counter <= stamp_counter + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        issue_idx <= '0;
        chk_valid <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.search) begin
        chk_valid <= issuing;
        if (issuing) begin
          issue_idx <= issue_idx + 1'b1;
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_kind     <= kind;
      ev_channel  <= midi_channel;
      ev_note     <= note_number;
      ev_velocity <= note_velocity;
      pick        <= '0;
      least       <= '1;
    end else if (cmd.search) begin
      chk_idx <= issue_idx[VW-1:0];
      if (hit) begin
        pick <= chk_idx;
        if (!is_on) begin
          least <= rd_stamp;
        end
      end else if (checking && is_on && (rd_stamp < least)) begin
        least <= rd_stamp;
        pick  <= chk_idx;
      end
    end
    if (cmd.commit) begin
      starts_voice <= is_on;
      out_channel  <= ev_channel;
      voice_slot   <= mvsa_pkg::SLOT_OUT_W'(pick);
      out_note     <= ev_note;
      out_velocity <= ev_velocity;
    end
  end

  mvsa_ram #(
    .WIDTH (mvsa_pkg::WORD_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/midi_voice_slot_allocator.sv -----
// MIDI voice slot allocator: top level joining controller and datapath.
// Depends on mvsa_pkg, mvsa_ctrl, mvsa_datapath and mvsa_ram.
//
// Each enabled MIDI channel owns MAX_VOICES slots in one slot RAM. A note-on
// takes the first inactive slot, or else the one with the oldest stamp; a
// note-off (or note-on with velocity zero) releases the first slot holding the
// note. One transaction is taken at a time, and the search reads one slot per
// cycle through the registered RAM port. A finished result waits in the output
// register while the next transaction is accepted. After reset the block clears
// the slot RAM, one entry per cycle, over all MAX_VOICES * MIDI_CHANNELS
// entries, and accepts no transaction until that pass ends; configuration
// writes are taken throughout.
`default_nettype none

module midi_voice_slot_allocator #(
  parameter int MAX_VOICES    = 8,
  parameter int MIDI_CHANNELS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mvsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mvsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [mvsa_pkg::CHANNEL_W-1:0]    midi_channel,
  input  logic [mvsa_pkg::NOTE_W-1:0]       note_number,
  input  logic [mvsa_pkg::VELOCITY_W-1:0]   note_velocity,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              starts_voice,
  output logic [mvsa_pkg::CHANNEL_W-1:0]    out_channel,
  output logic [mvsa_pkg::SLOT_OUT_W-1:0]   voice_slot,
  output logic [mvsa_pkg::NOTE_W-1:0]       out_note,
  output logic [mvsa_pkg::VELOCITY_W-1:0]   out_velocity
);

  mvsa_pkg::cmd_t    cmd;
  mvsa_pkg::status_t st;

  mvsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mvsa_datapath #(
    .MAX_VOICES    (MAX_VOICES),
    .MIDI_CHANNELS (MIDI_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .midi_channel  (midi_channel),
    .note_number   (note_number),
    .note_velocity (note_velocity),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .starts_voice  (starts_voice),
    .out_channel   (out_channel),
    .voice_slot    (voice_slot),
    .out_note      (out_note),
    .out_velocity  (out_velocity)
  );

  // No transaction may enter while the slot RAM is being cleared.
  assert property (@(posedge clk) disable iff (rst) cmd.clear |-> in_stall)
    else $error("transaction accepted during clearing pass");

  // A result only appears after a commit of the controller.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(cmd.commit))
    else $error("result shown without a commit");

  // A commit never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  // Clearing and committing never share the RAM write port.
  assert property (@(posedge clk) disable iff (rst) !(cmd.clear && cmd.commit))
    else $error("clear and commit in the same cycle");

endmodule

`default_nettype wire
